[hdl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator package
// Shared widths, constants, status codes and the structures that pass
// between the front end, the job queue and the calibration engine.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    // Channel count in use and retry holdoff length in milliseconds.
    localparam int CHANNELS    = 4;
    localparam int RETRY_TICKS = 5000;

    // Field widths.
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int PCT_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int HOLDOFF_W = 13;

    // Configuration register file: a dry and a wet point per channel.
    localparam int NUM_CAL_CH = 4;
    localparam int NUM_REGS   = 2 * NUM_CAL_CH;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);

    // Calibration constants.
    localparam logic [SAMPLE_W-1:0] WINDOW_MARGIN = 16'd2000;
    localparam logic [SAMPLE_W-1:0] FALLBACK_DRY  = 16'd10000;
    localparam logic [SAMPLE_W-1:0] FALLBACK_WET  = 16'd26000;
    localparam logic [SAMPLE_W-1:0] RAW_LIMIT     = 16'd32767;
    localparam logic [PCT_W-1:0]    PCT_MAX       = 7'd100;

    // Serial divider: the scaled numerator magnitude needs 23 bits.
    localparam int NUM_W  = SAMPLE_W + 8;
    localparam int DIV_W  = NUM_W - 1;
    localparam int STEP_W = $clog2(DIV_W);

    // Job queue between the front end and the calibration engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_HOLDOFF     = 3'd1,
        ST_PROBE_FAIL  = 3'd2,
        ST_READ_FAIL   = 3'd3,
        ST_RAW_INVALID = 3'd4
    } status_t;

    typedef logic [NUM_CAL_CH-1:0][SAMPLE_W-1:0] cal_points_t;

    typedef struct packed {
        status_t             status;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
    } job_t;

    typedef struct packed {
        status_t             status;
        logic [SAMPLE_W-1:0] raw;
        logic [PCT_W-1:0]    pct;
        logic                healthy;
    } result_t;

endpackage

`default_nettype wire

[hdl/msc_req_if.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator request channel
// Valid/ready channel that carries ticks and read requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_req_if import msc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                probe_ok;
    logic                read_ok;

    modport source (output valid, output operation, output channel, output sample,
                    output probe_ok, output read_ok, input ready);
    modport sink   (input valid, input operation, input channel, input sample,
                    input probe_ok, input read_ok, output ready);
endinterface

`default_nettype wire

[hdl/msc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator response channel
// Valid/ready channel that carries one result per read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_rsp_if import msc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] raw_out;
    logic [PCT_W-1:0]    moisture_pct;
    logic                healthy;

    modport source (output valid, output status, output raw_out,
                    output moisture_pct, output healthy, input ready);
    modport sink   (input valid, input status, input raw_out,
                    input moisture_pct, input healthy, output ready);
endinterface

`default_nettype wire

[hdl/msc_queue.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator job queue
// Small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_queue import msc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job queue written while full");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("job queue count lost track of a pop");

endmodule

`default_nettype wire

[hdl/msc_front.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator front end
// Accepts transactions, runs the presence and holdoff state, and queues
// one classified job per valid read request.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_front import msc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    msc_req_if.sink    req,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic                 present_reg;
    logic                 present_next;
    logic                 armed_reg;
    logic                 armed_next;
    logic [HOLDOFF_W-1:0] left_reg;
    logic [HOLDOFF_W-1:0] left_next;
    logic                 accept;
    logic                 ch_valid;
    status_t              status;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign ch_valid  = 32'(req.channel) < 32'(CHANNELS);

    always_comb
    begin
        present_next = present_reg;
        armed_next   = armed_reg;
        left_next    = left_reg;
        status       = ST_OK;
        q_push       = 1'b0;

        if (accept && !req.operation)
        begin
            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
            end
        end
        else if (accept && ch_valid)
        begin
            q_push = 1'b1;
            if (!present_reg && armed_reg && left_reg != '0)
            begin
                status = ST_HOLDOFF;
            end
            else if (!present_reg && !req.probe_ok)
            begin
                armed_next = 1'b1;
                left_next  = HOLDOFF_W'(RETRY_TICKS);
                status     = ST_PROBE_FAIL;
            end
            else if (!req.read_ok)
            begin
                // A failed read drops the converter and restarts the holdoff.
                present_next = 1'b0;
                armed_next   = 1'b1;
                left_next    = HOLDOFF_W'(RETRY_TICKS);
                status       = ST_READ_FAIL;
            end
            else
            begin
                present_next = 1'b1;
                armed_next   = 1'b0;
                if (req.sample == '0 || req.sample >= RAW_LIMIT)
                begin
                    status = ST_RAW_INVALID;
                end
            end
        end
    end

    assign q_job = '{status: status, ch: req.channel, raw: req.sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            armed_reg   <= 1'b0;
            left_reg    <= '0;
        end
        else
        begin
            present_reg <= present_next;
            armed_reg   <= armed_next;
            left_reg    <= left_next;
        end
    end

    a_present_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        !(present_reg && armed_reg))
        else $error("holdoff armed while the converter is present");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.operation && left_reg != '0) |=>
        left_reg == $past(left_reg) - 1'b1)
        else $error("tick did not count the holdoff down");

endmodule

`default_nettype wire

[hdl/msc_back.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator engine
// Takes queued jobs and forms the result: point selection, health window,
// and a radix-2 restoring divider for the scaled percentage.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_back import msc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cal_points_t dry_pts,
    input  cal_points_t wet_pts,
    input  logic        q_empty,
    input  job_t        q_data,
    output logic        q_pop,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    status_t             status_reg;
    status_t             status_next;
    logic [SAMPLE_W-1:0] raw_reg;
    logic [SAMPLE_W-1:0] raw_next;
    logic                healthy_reg;
    logic                healthy_next;
    logic                neg_reg;
    logic                neg_next;
    logic [DIV_W-1:0]    nq_reg;
    logic [DIV_W-1:0]    nq_next;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] rem_next;
    logic [SAMPLE_W-1:0] den_reg;
    logic [SAMPLE_W-1:0] den_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    logic [SAMPLE_W-1:0]        dry_cfg;
    logic [SAMPLE_W-1:0]        wet_cfg;
    logic                       calibrated;
    logic [SAMPLE_W-1:0]        dry_sel;
    logic [SAMPLE_W-1:0]        wet_sel;
    logic [SAMPLE_W-1:0]        lo_pt;
    logic [SAMPLE_W-1:0]        hi_pt;
    logic [SAMPLE_W-1:0]        lo_ok;
    logic [SAMPLE_W:0]          hi_ok;
    logic                       in_window;
    logic signed [SAMPLE_W:0]   diff_s;
    logic signed [SAMPLE_W:0]   den_s;
    logic signed [NUM_W-1:0]    num_s;
    logic [SAMPLE_W:0]          rem_shift;
    logic                       q_bit;
    logic [PCT_W-1:0]           pct;

    // Point selection and health window for the job at the queue head.
    always_comb
    begin
        dry_cfg    = dry_pts[q_data.ch];
        wet_cfg    = wet_pts[q_data.ch];
        calibrated = (dry_cfg != '0) && (wet_cfg != '0) && (dry_cfg != wet_cfg);
        dry_sel    = calibrated ? dry_cfg : FALLBACK_DRY;
        wet_sel    = calibrated ? wet_cfg : FALLBACK_WET;
        lo_pt      = (dry_cfg < wet_cfg) ? dry_cfg : wet_cfg;
        hi_pt      = (dry_cfg < wet_cfg) ? wet_cfg : dry_cfg;
        lo_ok      = (lo_pt > WINDOW_MARGIN) ? lo_pt - WINDOW_MARGIN : '0;
        hi_ok      = {1'b0, hi_pt} + {1'b0, WINDOW_MARGIN};
        in_window  = (q_data.raw >= lo_ok) && ({1'b0, q_data.raw} <= hi_ok);
        diff_s     = signed'({1'b0, q_data.raw}) - signed'({1'b0, dry_sel});
        den_s      = signed'({1'b0, wet_sel}) - signed'({1'b0, dry_sel});
        num_s      = NUM_W'(diff_s) * 24'sd100;
    end

    // One quotient bit per cycle.
    assign rem_shift = {rem_reg, nq_reg[DIV_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        if (neg_reg)
        begin
            pct = '0;
        end
        else if (nq_reg > DIV_W'(PCT_MAX))
        begin
            pct = PCT_MAX;
        end
        else
        begin
            pct = nq_reg[PCT_W-1:0];
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign res_valid = (state_reg == S_HOLD);
    assign res       = '{status: status_reg, raw: raw_reg, pct: pct,
                         healthy: healthy_reg};

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        raw_next     = raw_reg;
        healthy_next = healthy_reg;
        neg_next     = neg_reg;
        nq_next      = nq_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        step_next    = step_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    status_next = q_data.status;
                    if (q_data.status == ST_OK)
                    begin
                        raw_next     = q_data.raw;
                        healthy_next = !calibrated || in_window;
                        neg_next     = num_s[NUM_W-1] ^ den_s[SAMPLE_W];
                        nq_next      = num_s[NUM_W-1] ? DIV_W'(-num_s)
                                                      : num_s[DIV_W-1:0];
                        den_next     = den_s[SAMPLE_W] ? SAMPLE_W'(-den_s)
                                                       : den_s[SAMPLE_W-1:0];
                        rem_next     = '0;
                        step_next    = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        // Refused or failed reads report zeros.
                        raw_next     = '0;
                        healthy_next = 1'b0;
                        neg_next     = 1'b1;
                        state_next   = S_HOLD;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = q_bit ? SAMPLE_W'(rem_shift - {1'b0, den_reg})
                                  : rem_shift[SAMPLE_W-1:0];
                nq_next   = {nq_reg[DIV_W-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_OK;
            raw_reg     <= '0;
            healthy_reg <= 1'b0;
            neg_reg     <= 1'b0;
            nq_reg      <= '0;
            rem_reg     <= '0;
            den_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            raw_reg     <= raw_next;
            healthy_reg <= healthy_next;
            neg_reg     <= neg_next;
            nq_reg      <= nq_next;
            rem_reg     <= rem_next;
            den_reg     <= den_next;
            step_reg    <= step_next;
        end
    end

endmodule

`default_nettype wire

[hdl/moisture_sample_calibrator.sv]
// A tick updates the presence and holdoff state and gives no result; ticks are taken
// one per cycle while the queue is not full. A read passes through the job queue and
// the engine to the response register; a good read runs the serial divider (one quotient
// bit per cycle over 23 bits). The engine takes no new job until its last result is taken.
// Reset: rst_n clears the presence and holdoff state, the calibration points, the job
// queue, the engine and the response valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Moisture sample calibrator
// Two-point linear calibration of raw soil moisture samples to a clamped
// percentage, with converter presence tracking and a retry holdoff.
// ----------------------------------------------------------------------------
`default_nettype none

module moisture_sample_calibrator import msc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    msc_req_if.sink              req,
    msc_rsp_if.source            rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_wdata
);

    // Calibration points. Index 0..3 are the dry points and 4..7 the wet
    // points of channels 0..3. Writes must only happen while the block is idle;
    // the user must ensure it, as the block does not, and the engine reads them directly.
    cal_points_t dry_pts_reg;
    cal_points_t wet_pts_reg;

    // Front end to queue.
    logic q_push;
    job_t q_job;
    logic q_full;

    // Queue to engine.
    logic q_pop;
    job_t q_data;
    logic q_empty;

    // Engine to response register.
    logic    res_valid;
    result_t res;
    logic    res_take;

    // Response register: it lets the engine start the next job while the
    // previous result is still waiting for the downstream sink.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SAMPLE_W-1:0] out_raw_reg;
    logic [PCT_W-1:0]    out_pct_reg;
    logic                out_healthy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_pts_reg <= '0;
            wet_pts_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index < CFG_IDX_W'(NUM_CAL_CH))
            begin
                dry_pts_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_wdata;
            end
            else
            begin
                wet_pts_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_wdata;
            end
        end
    end

    // The front end classifies each read against the presence and holdoff
    // state at the moment of acceptance, so every later transaction sees
    // the state exactly as the earlier ones left it.
    msc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_job)
    );

    msc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Every queued job, failed or not, passes through the engine so that
    // results leave in the order the reads were accepted.
    msc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dry_pts   (dry_pts_reg),
        .wet_pts   (wet_pts_reg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_status_reg  <= res.status;
            out_raw_reg     <= res.raw;
            out_pct_reg     <= res.pct;
            out_healthy_reg <= res.healthy;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.raw_out      = out_raw_reg;
    assign rsp.moisture_pct = out_pct_reg;
    assign rsp.healthy      = out_healthy_reg;

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Moisture sample calibrator testbench
// Drives ticks and channel reads into the calibrator through its request
// channel, predicts each response from a behavioral copy of the presence,
// holdoff and two-point calibration logic, and checks every response field
// by field. Calibration points are reloaded between traffic phases while the
// block is idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb import msc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes carried in the request transaction.
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Calibration register map: dry points first, then wet points.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRY_CH0 = 3'd0,
        REG_DRY_CH1 = 3'd1,
        REG_DRY_CH2 = 3'd2,
        REG_DRY_CH3 = 3'd3,
        REG_WET_CH0 = 3'd4,
        REG_WET_CH1 = 3'd5,
        REG_WET_CH2 = 3'd6,
        REG_WET_CH3 = 3'd7
    } cal_reg_t;

    // One request transaction as the sender presents it.
    typedef struct packed {
        op_t                 op;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
        logic                probe_ok;
        logic                read_ok;
    } sample_req_t;

    // Converter presence and retry holdoff, as tracked by the block.
    typedef struct {
        logic                 present;
        logic                 armed;
        logic [HOLDOFF_W-1:0] left;
    } link_state_t;

    localparam int RAW_TOP       = RAW_LIMIT - 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_HOLDOFFS  = 24;
    // Worst case is dominated by the tick runs that wait out each holdoff:
    // about 25 holdoffs of 5000 ticks, each tick possibly behind a sender gap,
    // plus some 600 reads through the divider behind the longest response stall.
    localparam int CYCLE_LIMIT   = 4_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_wdata;

    msc_req_if req_ch ();
    msc_rsp_if rsp_ch ();

    moisture_sample_calibrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Calibration points as currently loaded into the block. They only change
    // while no transaction is in flight, so the generator and the checker can
    // share them.
    cal_points_t dry_points;
    cal_points_t wet_points;

    // Two copies of the link state: one that the generator advances while it
    // plans traffic, and one that follows the transactions the block accepts.
    link_state_t plan_state;
    link_state_t live_state;

    sample_req_t request_backlog[$];
    result_t     due_readings[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int holdoff_count  = 0;
    int cycle_count    = 0;

    // Sender burst control and receiver stall pattern.
    int          burst_left;
    int          gap_left;
    sample_req_t head_req;
    logic [15:0] ready_pattern;
    logic [3:0]  ready_phase;

    // ------------------------------------------------------------------------
    // Behavioral calibrator. Advances the link state by one transaction and
    // returns 1 when the transaction produces a response.
    // ------------------------------------------------------------------------
    function automatic bit calibrate_reading(inout link_state_t st, input sample_req_t rq,
                                             output result_t res);
        int  raw, dry, wet, pct, lo, hi, lo_ok;
        bit  calibrated;
        res = '0;
        if (rq.op == OP_TICK)
        begin
            if (st.left != 0)
                st.left = st.left - 1'b1;
            return 1'b0;
        end
        if (rq.ch >= CHANNELS)
            return 1'b0;

        if (!st.present && st.armed && st.left != 0)
        begin
            // Converter is absent and the retry holdoff has not run out yet.
            res.status = ST_HOLDOFF;
        end
        else if (!st.present && !rq.probe_ok)
        begin
            st.armed   = 1'b1;
            st.left    = HOLDOFF_W'(RETRY_TICKS);
            res.status = ST_PROBE_FAIL;
        end
        else
        begin
            // The probe outcome only matters while the converter is absent.
            if (!st.present)
            begin
                st.present = 1'b1;
                st.armed   = 1'b0;
            end
            if (!rq.read_ok)
            begin
                st.present = 1'b0;
                st.armed   = 1'b1;
                st.left    = HOLDOFF_W'(RETRY_TICKS);
                res.status = ST_READ_FAIL;
            end
            else if (rq.sample == 0 || rq.sample >= RAW_LIMIT)
            begin
                res.status = ST_RAW_INVALID;
            end
            else
            begin
                raw        = rq.sample;
                dry        = dry_points[rq.ch];
                wet        = wet_points[rq.ch];
                calibrated = dry != 0 && wet != 0 && dry != wet;
                if (!calibrated)
                begin
                    dry = FALLBACK_DRY;
                    wet = FALLBACK_WET;
                end
                // Signed division truncates toward zero, then clamp to 0..100.
                pct = ((raw - dry) * 100) / (wet - dry);
                if (pct < 0)
                    pct = 0;
                else if (pct > PCT_MAX)
                    pct = PCT_MAX;
                lo    = dry < wet ? dry : wet;
                hi    = dry > wet ? dry : wet;
                lo_ok = lo > WINDOW_MARGIN ? lo - WINDOW_MARGIN : 0;
                res.status  = ST_OK;
                res.raw     = rq.sample;
                res.pct     = PCT_W'(pct);
                res.healthy = !calibrated || (raw >= lo_ok && raw <= hi + WINDOW_MARGIN);
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Appends one transaction to the backlog and reports the status it will
    // get, so that the generator can steer toward the deeper states.
    function automatic status_t queue_request(input op_t op, input int ch, input int sample,
                                              input bit probe, input bit link);
        sample_req_t rq;
        result_t     outcome;
        rq.op       = op;
        rq.ch       = CH_W'(ch);
        rq.sample   = SAMPLE_W'(sample);
        rq.probe_ok = probe;
        rq.read_ok  = link;
        void'(calibrate_reading(plan_state, rq, outcome));
        request_backlog.push_back(rq);
        queued_count++;
        return outcome.status;
    endfunction

    // Samples are mostly drawn around the channel's calibration points, with
    // a share of out-of-range and full-span values.
    function automatic int pick_sample(input int ch);
        int roll, anchor, value;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return 0;
        if (roll < 9)
            return $urandom_range(RAW_LIMIT, 65535);
        if (roll < 30)
            return $urandom_range(1, RAW_TOP);
        anchor = $urandom_range(0, 1) ? dry_points[ch] : wet_points[ch];
        if (anchor == 0)
            anchor = FALLBACK_DRY;
        value = anchor + int'($urandom_range(0, 6000)) - 3000;
        if (value < 1)
            value = 1;
        else if (value > RAW_TOP)
            value = RAW_TOP;
        return value;
    endfunction

    // Mostly good reads with random content. A failed probe or read is thrown
    // in now and then; the holdoff it starts is then worn down by a run of
    // ticks, with a few reads that land inside it, some right at its end.
    task automatic random_traffic(input int reads);
        int      done, roll, ch;
        bit      failing, probe, link;
        status_t outcome;
        done = 0;
        while (done < reads)
        begin
            roll = $urandom_range(0, 99);
            ch   = $urandom_range(0, 3);
            if (!plan_state.present && plan_state.armed && plan_state.left != 0)
            begin
                if (roll < 2 || (plan_state.left <= 3 && roll < 40))
                begin
                    outcome = queue_request(OP_READ, ch, pick_sample(ch),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)));
                    done++;
                end
                else
                begin
                    outcome = queue_request(OP_TICK, ch, $urandom_range(0, 65535),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)));
                end
            end
            else if (roll < 10)
            begin
                outcome = queue_request(OP_TICK, ch, $urandom_range(0, 65535),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)));
            end
            else
            begin
                failing = holdoff_count < MAX_HOLDOFFS;
                if (plan_state.present)
                    probe = 1'($urandom_range(0, 1));
                else
                    probe = !(failing && $urandom_range(0, 3) == 0);
                link    = !(failing && $urandom_range(0, 32) == 0);
                outcome = queue_request(OP_READ, ch, pick_sample(ch), probe, link);
                if (outcome == ST_PROBE_FAIL || outcome == ST_READ_FAIL)
                    holdoff_count++;
                done++;
            end
        end
    endtask

    // Writes all eight calibration registers, one per clock edge.
    task automatic load_calibration(input cal_points_t dry, input cal_points_t wet);
        for (int ch = 0; ch < NUM_CAL_CH; ch++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cal_reg_t'(REG_DRY_CH0 + ch);
            cfg_wdata <= dry[ch];
            @(posedge clk);
            cfg_index <= cal_reg_t'(REG_WET_CH0 + ch);
            cfg_wdata <= wet[ch];
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dry_points = dry;
        wet_points = wet;
    endtask

    // Random calibration sets: typical capacitive probes (dry reads higher),
    // the reverse, missing or equal points, very narrow spans and full range.
    task automatic random_calibration();
        cal_points_t dry, wet;
        int          roll;
        for (int ch = 0; ch < NUM_CAL_CH; ch++)
        begin
            roll = $urandom_range(0, 9);
            case (roll)
                0:
                begin
                    dry[ch] = $urandom_range(0, 1) ? 16'd0
                                                   : SAMPLE_W'($urandom_range(1, 65535));
                    wet[ch] = dry[ch] == 0 ? SAMPLE_W'($urandom_range(0, 65535)) : 16'd0;
                end
                1:
                begin
                    dry[ch] = SAMPLE_W'($urandom_range(1, 65535));
                    wet[ch] = dry[ch];
                end
                2:
                begin
                    dry[ch] = SAMPLE_W'($urandom_range(1, 32000));
                    wet[ch] = dry[ch] + SAMPLE_W'($urandom_range(1, 4));
                end
                3:
                begin
                    dry[ch] = SAMPLE_W'($urandom_range(0, 65535));
                    wet[ch] = SAMPLE_W'($urandom_range(0, 65535));
                end
                4, 5:
                begin
                    dry[ch] = SAMPLE_W'($urandom_range(3000, 16000));
                    wet[ch] = SAMPLE_W'($urandom_range(14000, 30000));
                end
                default:
                begin
                    dry[ch] = SAMPLE_W'($urandom_range(14000, 30000));
                    wet[ch] = SAMPLE_W'($urandom_range(3000, 16000));
                end
            endcase
        end
        load_calibration(dry, wet);
    endtask

    // Waits until every queued transaction has been accepted and answered,
    // then lets the clock run on with no traffic before the next phase.
    task automatic settle();
        while (accepted_count != queued_count || due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: works in bursts of random length separated by random
    // gaps. A third of the gaps are empty, which gives back-to-back stretches.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_TICK;
            req_ch.channel   <= '0;
            req_ch.sample    <= '0;
            req_ch.probe_ok  <= 1'b0;
            req_ch.read_ok   <= 1'b0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left != 0)
            begin
                req_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (request_backlog.size() != 0)
            begin
                head_req          = request_backlog.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= head_req.op;
                req_ch.channel   <= head_req.ch;
                req_ch.sample    <= head_req.sample;
                req_ch.probe_ok  <= head_req.probe_ok;
                req_ch.read_ok   <= head_req.read_ok;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Every accepted request transaction advances the live link state; a read
    // that is answered leaves its expected response in order.
    always @(posedge clk)
    begin
        sample_req_t taken;
        result_t     due;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            taken.op       = op_t'(req_ch.operation);
            taken.ch       = req_ch.channel;
            taken.sample   = req_ch.sample;
            taken.probe_ok = req_ch.probe_ok;
            taken.read_ok  = req_ch.read_ok;
            if (calibrate_reading(live_state, taken, due))
                due_readings.push_back(due);
            accepted_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: ready follows a 16-bit pattern that is redrawn on each
    // wrap, all ones a quarter of the time so that some stretches never stall.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready  <= 1'b0;
            ready_pattern <= 16'hFFFF;
            ready_phase   <= '0;
        end
        else
        begin
            rsp_ch.ready <= ready_pattern[ready_phase];
            ready_phase  <= ready_phase + 1'b1;
            if (ready_phase == 4'hF)
            begin
                if ($urandom_range(0, 3) == 0)
                    ready_pattern <= 16'hFFFF;
                else
                    ready_pattern <= 16'($urandom_range(0, 65535)) | 16'h0001;
            end
        end
    end

    // Each response transaction is checked against the oldest expectation.
    // Values are printed as status/raw/percent/healthy.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: unexpected response %0d/%0d/%0d/%0d",
                             rsp_ch.status, rsp_ch.raw_out, rsp_ch.moisture_pct,
                             rsp_ch.healthy);
            end
            else
            begin
                want = due_readings.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.raw_out !== want.raw ||
                    rsp_ch.moisture_pct !== want.pct || rsp_ch.healthy !== want.healthy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 want.status, want.raw, want.pct, want.healthy,
                                 rsp_ch.status, rsp_ch.raw_out, rsp_ch.moisture_pct,
                                 rsp_ch.healthy);
                end
            end
        end
    end

    // A hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cal_points_t dry, wet;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_TICK;
        req_ch.channel   = '0;
        req_ch.sample    = '0;
        req_ch.probe_ok  = 1'b0;
        req_ch.read_ok   = 1'b0;
        rsp_ch.ready     = 1'b0;
        dry_points       = '0;
        wet_points       = '0;
        plan_state       = '{1'b0, 1'b0, '0};
        live_state       = '{1'b0, 1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset calibration: every channel falls back to 10000 dry, 26000 wet.
        // The first read also detects the converter. Covers the sample limits,
        // both fallback points, the midpoint, a slightly negative quotient that
        // truncates to zero, and a failed probe that is ignored once present.
        void'(queue_request(OP_TICK, 3, 65535, 1, 1));
        void'(queue_request(OP_READ, 0, 1, 1, 1));
        void'(queue_request(OP_READ, 1, RAW_TOP, 1, 1));
        void'(queue_request(OP_READ, 2, 0, 1, 1));
        void'(queue_request(OP_READ, 3, RAW_LIMIT, 1, 1));
        void'(queue_request(OP_READ, 0, 65535, 1, 1));
        void'(queue_request(OP_READ, 1, FALLBACK_DRY, 1, 1));
        void'(queue_request(OP_READ, 2, FALLBACK_WET, 1, 1));
        void'(queue_request(OP_READ, 3, 18000, 1, 1));
        void'(queue_request(OP_READ, 0, FALLBACK_DRY - 1, 1, 1));
        void'(queue_request(OP_READ, 1, 18001, 0, 1));
        settle();

        // Inverted full-span points, a 20000..24000 window probed at each edge
        // of its widened range, a one-count span whose low edge sits at 1, and
        // a channel left uncalibrated by a zero dry point. Then a failed read,
        // and reads refused while the holdoff runs.
        dry = {16'd0, 16'd2001, 16'd20000, 16'd65535};
        wet = {16'd65535, 16'd2002, 16'd24000, 16'd1};
        load_calibration(dry, wet);
        void'(queue_request(OP_READ, 0, 100, 1, 1));
        void'(queue_request(OP_READ, 1, 17999, 1, 1));
        void'(queue_request(OP_READ, 1, 18000, 1, 1));
        void'(queue_request(OP_READ, 1, 26000, 1, 1));
        void'(queue_request(OP_READ, 1, 26001, 1, 1));
        void'(queue_request(OP_READ, 2, 1, 1, 1));
        void'(queue_request(OP_READ, 3, 20000, 1, 1));
        void'(queue_request(OP_READ, 0, 12000, 1, 0));
        void'(queue_request(OP_READ, 2, 12000, 1, 1));
        void'(queue_request(OP_TICK, 0, 0, 0, 0));
        void'(queue_request(OP_READ, 3, 12000, 0, 1));
        settle();

        // Opposite extremes: full-span rising points, a low point exactly at
        // the margin, equal points at the top, and a zero wet point.
        dry = {16'd30000, 16'd65535, 16'd2000, 16'd1};
        wet = {16'd0, 16'd65535, 16'd32766, 16'd65535};
        load_calibration(dry, wet);
        random_traffic(100);
        settle();

        repeat (4)
        begin
            random_calibration();
            random_traffic(100);
            settle();
        end

        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[moisture_sample_calibrator.f]
hdl/msc_pkg.sv
hdl/msc_req_if.sv
hdl/msc_rsp_if.sv
hdl/msc_queue.sv
hdl/msc_front.sv
hdl/msc_back.sv
hdl/moisture_sample_calibrator.sv
bench/tb.sv
